// ===== rtl/core/nfsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared widths, codes and types for the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    localparam int SLOT_W    = 10;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 11;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int SLOTS_DEF = 1024;
    localparam int CAP_MAX   = 1024;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_op OP_ALLOC = 2'd0;
    localparam t_op OP_FREE  = 2'd1;
    localparam t_op OP_QUERY = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_RANGE    = 2'd2;
    localparam t_status ST_WAS_FREE = 2'd3;

endpackage

// ===== rtl/core/nfsa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_if
// Valid/ready channels of the allocator: request, response, configuration.
// ----------------------------------------------------------------------------
interface nfsa_req_if import nfsa_pkg::*; ();
    logic  valid;
    logic  ready;
    t_op   op;
    t_slot slot;

    modport source (output valid, output op, output slot, input ready);
    modport sink   (input valid, input op, input slot, output ready);
endinterface

interface nfsa_rsp_if import nfsa_pkg::*; ();
    logic    valid;
    logic    ready;
    t_slot   slot_out;
    t_status status;

    modport source (output valid, output slot_out, output status, input ready);
    modport sink   (input valid, input slot_out, input status, output ready);
endinterface

interface nfsa_cfg_if import nfsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== rtl/core/next_fit_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Next-fit allocator over a pool of slots kept as a 32-bit word bitmap.
// ----------------------------------------------------------------------------
// The occupancy map lives in a single-port RAM of 32-slot words with
// registered read data; a per-word valid bit cleared at reset stands in for
// clearing the map, so no sweep is needed after reset. One item is in work
// at a time. An in-range free or query passes READ, EVAL and WAIT before
// the next acceptance; an out-of-range slot or an unused op code goes
// straight to WAIT. Allocate repeats READ and EVAL once per word visited,
// from the word of the start slot until a free slot is found or the scan
// returns to the start word, so it runs longest when the pool is nearly full;
// the word read and scan of the one shared priority encoder sets its pace. A
// finished response waits in an output register, and the next item is
// accepted meanwhile. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator
    import nfsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfsa_cfg_if.sink    i_cfg,
    nfsa_req_if.sink    i_req,
    nfsa_rsp_if.source  o_rsp
);

    localparam int CAP_LIMIT = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
    localparam int ROWS      = (CAP_LIMIT + WORD_W - 1) / WORD_W;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [CAP_W-1:0]  r_capacity;
    logic [1:0]        r_state;
    t_op               r_op;
    t_slot             r_slot;
    t_slot             r_start;
    t_slot             r_next_slot;
    logic [CAP_W-1:0]  r_cap;
    logic [ROW_W-1:0]  r_row;
    logic              r_first;
    t_slot             r_pend_slot;
    t_status           r_pend_status;
    logic              r_out_valid;
    t_slot             r_out_slot;
    t_status           r_out_status;

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvld;

    logic [CAP_W-1:0]  cap;
    logic              in_range;
    t_slot             start;
    logic              req_acc;
    logic              out_load;

    t_slot             cap_m1;
    logic [ROW_W-1:0]  last_row;
    logic [ROW_W-1:0]  start_row;
    logic              final_visit;
    logic [BIT_W:0]    lo;
    logic [BIT_W:0]    hi;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] cand;
    logic              found;
    logic [BIT_W-1:0]  enc;
    t_slot             hit_idx;
    logic [CAP_W-1:0]  hit_inc;
    logic              occ_bit;
    logic [WORD_W-1:0] bit_sel;

    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.slot_out = r_out_slot;
    assign o_rsp.status   = r_out_status;
    assign out_load       = (r_state == S_WAIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        if (r_capacity == '0) begin
            cap = CAP_W'(1);
        end else if (r_capacity > CAP_W'(CAP_LIMIT)) begin
            cap = CAP_W'(CAP_LIMIT);
        end else begin
            cap = r_capacity;
        end
        in_range = {1'b0, i_req.slot} < cap;
        start    = ({1'b0, r_next_slot} < cap) ? r_next_slot : '0;
    end

    // scan window of the current word
    always_comb begin
        cap_m1      = SLOT_W'(r_cap - CAP_W'(1));
        last_row    = cap_m1[BIT_W +: ROW_W];
        start_row   = r_start[BIT_W +: ROW_W];
        final_visit = !r_first && (r_row == start_row);
        lo = (r_first && r_row == start_row) ? {1'b0, r_start[BIT_W-1:0]} : '0;
        if (final_visit) begin
            hi = {1'b0, r_start[BIT_W-1:0]};
        end else if (r_row == last_row) begin
            hi = {1'b0, cap_m1[BIT_W-1:0]} + (BIT_W+1)'(1);
        end else begin
            hi = (BIT_W+1)'(WORD_W);
        end
        word = r_rvld ? r_rdata : '0;
        for (int b = 0; b < WORD_W; b++) begin
            cand[b] = !word[b] && ((BIT_W+1)'(b) >= lo) && ((BIT_W+1)'(b) < hi);
        end
        found = 1'b0;
        enc   = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                found = 1'b1;
                enc   = BIT_W'(b);
            end
        end
        hit_idx = SLOT_W'({r_row, enc});
        hit_inc = {1'b0, hit_idx} + CAP_W'(1);
        occ_bit = word[r_slot[BIT_W-1:0]];
        bit_sel = WORD_W'(1) << (r_op == OP_ALLOC ? enc : r_slot[BIT_W-1:0]);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = word;
        if (r_state == S_EVAL) begin
            if (r_op == OP_ALLOC && found) begin
                mem_we    = 1'b1;
                mem_wdata = word | bit_sel;
            end else if (r_op == OP_FREE && occ_bit) begin
                mem_we    = 1'b1;
                mem_wdata = word & ~bit_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_row] <= mem_wdata;
        end
        r_rdata <= r_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rvld    <= 1'b0;
        end else begin
            if (mem_we) begin
                r_row_vld[r_row] <= 1'b1;
            end
            r_rvld <= r_row_vld[r_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_state     <= S_IDLE;
            r_next_slot <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end

            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_slot   <= r_pend_slot;
                r_out_status <= r_pend_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_op          <= i_req.op;
                        r_slot        <= i_req.slot;
                        r_cap         <= cap;
                        r_start       <= start;
                        r_first       <= 1'b1;
                        r_pend_slot   <= i_req.slot;
                        r_pend_status <= ST_RANGE;
                        unique case (i_req.op) inside
                            OP_ALLOC: begin
                                r_row   <= start[BIT_W +: ROW_W];
                                r_state <= S_READ;
                            end
                            OP_FREE, OP_QUERY: begin
                                r_row   <= i_req.slot[BIT_W +: ROW_W];
                                r_state <= in_range ? S_READ : S_WAIT;
                            end
                            default: begin
                                r_state <= S_WAIT;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_op == OP_ALLOC) begin
                        if (found) begin
                            r_pend_slot   <= hit_idx;
                            r_pend_status <= ST_OK;
                            r_next_slot   <= (hit_inc >= r_cap) ? '0 : SLOT_W'(hit_inc);
                            r_state       <= S_WAIT;
                        end else if (final_visit) begin
                            r_pend_slot   <= '0;
                            r_pend_status <= ST_FULL;
                            r_state       <= S_WAIT;
                        end else begin
                            r_row   <= (r_row == last_row) ? '0 : ROW_W'(r_row + 1'b1);
                            r_first <= 1'b0;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_pend_status <= occ_bit ? ST_OK : ST_WAS_FREE;
                        r_state       <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/nfsa_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module nfsa_chk
    import nfsa_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input logic    i_rsp_valid,
    input logic    i_rsp_ready,
    input t_slot   i_rsp_slot,
    input t_status i_rsp_status
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_slot)
            && $stable(i_rsp_status))
        else $error("response changed while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("item accepted while another is in work");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_FULL |-> i_rsp_slot == '0)
        else $error("full response with nonzero slot");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && i_req_ready)
        else $error("not idle after reset");

endmodule

bind next_fit_slot_allocator nfsa_chk u_nfsa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_slot   (o_rsp.slot_out),
    .i_rsp_status (o_rsp.status)
);
